>>> hw/rtl/fifo_queue_with_search_top_defines.svh
// assertion macros for the fifo queue with search
`ifndef FIFO_QUEUE_WITH_SEARCH_TOP_DEFINES_SVH
`define FIFO_QUEUE_WITH_SEARCH_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define FQS_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fifo queue check failed");

// next-cycle implication, sampled on clk, off during rst
`define FQS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fifo queue check failed");

`endif

>>> hw/rtl/fqs_pkg.sv
// shared types and constants for the fifo queue with search
`timescale 1ns / 1ps
package fqs_pkg;

  localparam int DEFAULT_DEPTH = 16;
  localparam int DATA_W        = 32;
  localparam int FUNC_W        = 2;
  localparam int STATUS_W      = 2;

  typedef enum logic [FUNC_W-1:0] {
    OP_ENQ    = 2'd0,
    OP_DEQ    = 2'd1,
    OP_PEEK   = 2'd2,
    OP_SEARCH = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    status_t status;
    logic    is_empty;
    logic    hit;
  } res_flags_t;

endpackage

>>> hw/rtl/fifo_queue_with_search_top.sv
// top level of the fifo queue with membership search
//
// channel  dir  fields (low bit up)
// s_*      in   tdata: operand_value[31:0]; tuser: func[1:0]
// m_*      out  tdata: result_value, hit, is_empty, fill_count, status, zero pad
//
// one transaction at a time; enqueue and a dequeue/peek when empty answer directly,
// a dequeue/peek first reads the head; search reads the filled entries in turn through
// the single ram read port; a waiting result does not block the next accept
// m_tready low holds the result and stalls only the final hand-off of the next
// rst clears pointers and count; the entry store needs no clearing
`timescale 1ns / 1ps
module fifo_queue_with_search_top import fqs_pkg::*; #(
  parameter  int DEPTH = DEFAULT_DEPTH,
  localparam int AW    = $clog2(DEPTH),
  localparam int CW    = $clog2(DEPTH + 1),
  localparam int OUT_W = ((DATA_W + 2 + CW + STATUS_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,  // operand_value
  input  logic [FUNC_W-1:0] s_tuser,  // func
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata   // result_value, hit, is_empty, fill_count, status
);

  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic signed [DATA_W-1:0] wr_data;
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic signed [DATA_W-1:0] rd_data;
  logic                     res_valid;
  logic signed [DATA_W-1:0] res_value;
  logic [CW-1:0]            res_count;
  res_flags_t               res_flags;
  logic                     out_free;

  fqs_ctrl #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .func          (s_tuser),
    .operand_value (s_tdata),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .res_valid     (res_valid),
    .res_value     (res_value),
    .res_count     (res_count),
    .res_flags     (res_flags),
    .out_free      (out_free)
  );

  fqs_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  fqs_outreg #(.CW(CW), .OUT_W(OUT_W)) u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_value (res_value),
    .res_count (res_count),
    .res_flags (res_flags),
    .out_free  (out_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

>>> hw/rtl/fqs_ram.sv
// entry store: one write port, one registered read port
`timescale 1ns / 1ps
module fqs_ram import fqs_pkg::*; #(
  parameter int DEPTH = DEFAULT_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic signed [DATA_W-1:0] wr_data,
  input  logic                     rd_en,
  input  logic [AW-1:0]            rd_addr,
  output logic signed [DATA_W-1:0] rd_data
);

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/fqs_ctrl.sv
// queue control: pointers, fill count, head read and search walk
`timescale 1ns / 1ps
module fqs_ctrl import fqs_pkg::*; #(
  parameter int DEPTH = DEFAULT_DEPTH,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [FUNC_W-1:0]        func,
  input  logic signed [DATA_W-1:0] operand_value,
  output logic                     wr_en,
  output logic [AW-1:0]            wr_addr,
  output logic signed [DATA_W-1:0] wr_data,
  output logic                     rd_en,
  output logic [AW-1:0]            rd_addr,
  input  logic signed [DATA_W-1:0] rd_data,
  output logic                     res_valid,
  output logic signed [DATA_W-1:0] res_value,
  output logic [CW-1:0]            res_count,
  output res_flags_t               res_flags,
  input  logic                     out_free
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_HEAD = 4'b0010,
    S_SCAN = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t                   state, state_next;
  logic [AW-1:0]            head, head_next;
  logic [AW-1:0]            tail, tail_next;
  logic [CW-1:0]            count, count_next;
  op_t                      op, op_next;
  logic signed [DATA_W-1:0] key, key_next;
  logic [AW-1:0]            ptr, ptr_next;
  logic [CW-1:0]            left, left_next;
  logic signed [DATA_W-1:0] value, value_next;
  logic                     hit, hit_next;
  status_t                  status, status_next;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    state_next  = state;
    head_next   = head;
    tail_next   = tail;
    count_next  = count;
    op_next     = op;
    key_next    = key;
    ptr_next    = ptr;
    left_next   = left;
    value_next  = value;
    hit_next    = hit;
    status_next = status;
    wr_en       = 1'b0;
    wr_addr     = tail;
    wr_data     = operand_value;
    rd_en       = 1'b0;
    rd_addr     = head;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_next     = op_t'(func);
          key_next    = operand_value;
          value_next  = '0;
          hit_next    = 1'b0;
          status_next = ST_OK;
          state_next  = S_EMIT;
          case (op_t'(func))
            OP_ENQ: begin
              if (count == CW'(DEPTH)) begin
                status_next = ST_FULL;
              end else begin
                wr_en      = 1'b1;
                tail_next  = ring_inc(tail);
                count_next = count + 1'b1;
              end
            end
            OP_DEQ, OP_PEEK: begin
              if (count == '0) begin
                status_next = ST_EMPTY;
              end else begin
                rd_en      = 1'b1;
                state_next = S_HEAD;
              end
            end
            OP_SEARCH: begin
              if (count != '0) begin
                rd_en      = 1'b1;
                ptr_next   = ring_inc(head);
                left_next  = count - 1'b1;
                state_next = S_SCAN;
              end
            end
            default: begin
              state_next = S_EMIT;
            end
          endcase
        end
      end
      S_HEAD: begin
        value_next = rd_data;
        hit_next   = 1'b1;
        if (op == OP_DEQ) begin
          head_next  = ring_inc(head);
          count_next = count - 1'b1;
        end
        state_next = S_EMIT;
      end
      S_SCAN: begin
        if (rd_data == key) begin
          hit_next   = 1'b1;
          state_next = S_EMIT;
        end else if (left == '0) begin
          state_next = S_EMIT;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = ptr;
          ptr_next  = ring_inc(ptr);
          left_next = left - 1'b1;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    op     <= op_next;
    key    <= key_next;
    ptr    <= ptr_next;
    left   <= left_next;
    value  <= value_next;
    hit    <= hit_next;
    status <= status_next;
  end

  assign in_ready           = (state == S_IDLE);
  assign res_valid          = (state == S_EMIT);
  assign res_value          = value;
  assign res_count          = count;
  assign res_flags.status   = status;
  assign res_flags.is_empty = (count == '0);
  assign res_flags.hit      = hit;

endmodule

>>> hw/rtl/fqs_outreg.sv
// output register that packs and holds one result transaction
`timescale 1ns / 1ps
module fqs_outreg import fqs_pkg::*; #(
  parameter int CW    = 5,
  parameter int OUT_W = 48
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     res_valid,
  input  logic signed [DATA_W-1:0] res_value,
  input  logic [CW-1:0]            res_count,
  input  res_flags_t               res_flags,
  output logic                     out_free,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_W-1:0]         m_tdata
);

  logic load;

  assign out_free = !m_tvalid || m_tready;
  assign load     = res_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= OUT_W'({res_flags.status, res_count, res_flags.is_empty,
                         res_flags.hit, res_value});
    end
  end

endmodule

>>> hw/rtl/fqs_checker.sv
// port-level checks for the fifo queue with search, bound to the top level
`timescale 1ns / 1ps
`include "fifo_queue_with_search_top_defines.svh"
module fqs_checker import fqs_pkg::*; #(
  parameter  int DEPTH = DEFAULT_DEPTH,
  localparam int CW    = $clog2(DEPTH + 1),
  localparam int OUT_W = ((DATA_W + 2 + CW + STATUS_W + 7) / 8) * 8
) (
  input logic              clk,
  input logic              rst,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [OUT_W-1:0]  m_tdata
);

  localparam int EMP_B  = DATA_W + 1;
  localparam int CNT_LO = DATA_W + 2;
  localparam int ST_LO  = DATA_W + 2 + CW;

  logic [DATA_W-1:0]   value;
  logic                hit;
  logic                empty;
  logic [CW-1:0]       cnt;
  logic [STATUS_W-1:0] st;

  assign value = m_tdata[DATA_W-1:0];
  assign hit   = m_tdata[DATA_W];
  assign empty = m_tdata[EMP_B];
  assign cnt   = m_tdata[CNT_LO +: CW];
  assign st    = m_tdata[ST_LO +: STATUS_W];

  `FQS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `FQS_ASSERT_IMPL(a_cnt_range, m_tvalid, cnt <= CW'(DEPTH))
  `FQS_ASSERT_IMPL(a_empty_flag, m_tvalid, empty == (cnt == '0))
  `FQS_ASSERT_IMPL(a_full_drop, m_tvalid && st == ST_FULL, cnt == CW'(DEPTH) && !hit && value == '0)
  `FQS_ASSERT_IMPL(a_empty_read, m_tvalid && st == ST_EMPTY, empty && !hit && value == '0)

endmodule

bind fifo_queue_with_search_top fqs_checker #(.DEPTH(DEPTH)) u_fqs_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
